/* src/coau_pkg.sv */
// coau_pkg: types and constants of the 6502 operand address unit
// no dependencies; used by the interfaces and every module of the block
package coau_pkg;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MODE_W  = 4;
    localparam int unsigned PHASE_W = 3;

    localparam logic [MODE_W-1:0] MODE_IMM  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ZP   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_ZPX  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_ABS  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ABSX = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ABSY = 4'd5;
    localparam logic [MODE_W-1:0] MODE_INDX = 4'd6;
    localparam logic [MODE_W-1:0] MODE_INDY = 4'd7;
    localparam logic [MODE_W-1:0] MODE_IND  = 4'd8;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [BYTE_W-1:0] ZP_PAGE = 8'h00;

    typedef struct packed {
        logic              func;
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] start_pc;
        logic [BYTE_W-1:0] index_x;
        logic [BYTE_W-1:0] index_y;
        logic [BYTE_W-1:0] bus_data;
    } in_word_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_addr;
        logic [ADDR_W-1:0] effective_addr;
        logic [ADDR_W-1:0] operand_value;
        logic [ADDR_W-1:0] next_pc;
        logic              protocol_error;
    } out_word_t;

    typedef struct packed {
        logic               busy;
        logic [MODE_W-1:0]  mode;
        logic [PHASE_W-1:0] phase;
        logic [ADDR_W-1:0]  pc;
        logic [BYTE_W-1:0]  x;
        logic [BYTE_W-1:0]  y;
        logic [ADDR_W-1:0]  pointer;
        logic [BYTE_W-1:0]  low_byte;
    } seq_state_t;

endpackage

/* src/coau_in_if.sv */
// coau_in_if: valid/ready channel carrying one input word of the unit
// depends on coau_pkg
interface coau_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [coau_pkg::MODE_W-1:0] mode;
    logic [coau_pkg::ADDR_W-1:0] start_pc;
    logic [coau_pkg::BYTE_W-1:0] index_x;
    logic [coau_pkg::BYTE_W-1:0] index_y;
    logic [coau_pkg::BYTE_W-1:0] bus_data;

    modport source (output valid, func, mode, start_pc, index_x, index_y, bus_data,
                    input ready);
    modport sink (input valid, func, mode, start_pc, index_x, index_y, bus_data,
                  output ready);
endinterface

/* src/coau_out_if.sv */
// coau_out_if: valid/ready channel carrying one result word of the unit
// depends on coau_pkg
interface coau_out_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [coau_pkg::ADDR_W-1:0] read_addr;
    logic [coau_pkg::ADDR_W-1:0] effective_addr;
    logic [coau_pkg::ADDR_W-1:0] operand_value;
    logic [coau_pkg::ADDR_W-1:0] next_pc;
    logic                       protocol_error;

    modport source (output valid, kind, read_addr, effective_addr, operand_value,
                    next_pc, protocol_error, input ready);
    modport sink (input valid, kind, read_addr, effective_addr, operand_value,
                  next_pc, protocol_error, output ready);
endinterface

/* src/coau_step.sv */
// coau_step: next sequencer state and result word for one accepted input word
// depends on coau_pkg
module coau_step (
    input  coau_pkg::seq_state_t st,
    input  coau_pkg::in_word_t   word,
    output coau_pkg::seq_state_t st_next,
    output coau_pkg::out_word_t  res
);
    import coau_pkg::*;

    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] hi_lo;
    logic [BYTE_W-1:0] zp_sum;
    logic [BYTE_W-1:0] ptr_inc;
    logic [BYTE_W-1:0] abs_idx;

    always_comb
    begin
        len = ((st.mode == MODE_ABS) || (st.mode == MODE_ABSX) || (st.mode == MODE_ABSY)
               || (st.mode == MODE_IND)) ? 16'd2 : 16'd1;
        hi_lo   = {word.bus_data, st.low_byte};
        zp_sum  = word.bus_data + (((st.mode == MODE_ZPX) || (st.mode == MODE_INDX))
                                   ? st.x : 8'h00);
        ptr_inc = st.pointer[BYTE_W-1:0] + 8'd1;
        abs_idx = (st.mode == MODE_ABSX) ? st.x
                : ((st.mode == MODE_ABSY) || (st.mode == MODE_INDY)) ? st.y : 8'h00;
    end

    always_comb
    begin
        st_next = st;
        res     = '0;
        res.kind = KIND_READ;
        if (word.func == FUNC_START)
        begin
            if (st.busy)
            begin
                res.read_addr      = st.pointer;
                res.protocol_error = 1'b1;
            end
            else if (word.mode > MODE_IND)
            begin
                res.kind    = KIND_DONE;
                res.next_pc = word.start_pc;
            end
            else
            begin
                st_next.busy     = 1'b1;
                st_next.mode     = word.mode;
                st_next.pc       = word.start_pc;
                st_next.x        = word.index_x;
                st_next.y        = word.index_y;
                st_next.phase    = '0;
                st_next.pointer  = word.start_pc;
                st_next.low_byte = '0;
                res.read_addr    = word.start_pc;
            end
        end
        else if (!st.busy)
        begin
            res.kind           = KIND_DONE;
            res.protocol_error = 1'b1;
        end
        else
        begin
            // request by default, overridden where the mode completes
            st_next.phase = st.phase + 3'd1;
            unique case (st.mode)
                MODE_IMM:
                begin
                    res.kind           = KIND_DONE;
                    res.operand_value  = {ZP_PAGE, word.bus_data};
                end
                MODE_ZP, MODE_ZPX:
                begin
                    if (st.phase == 3'd0)
                        st_next.pointer = {ZP_PAGE, zp_sum};
                    else
                    begin
                        res.kind           = KIND_DONE;
                        res.effective_addr = st.pointer;
                        res.operand_value  = {ZP_PAGE, word.bus_data};
                    end
                end
                MODE_ABS, MODE_ABSX, MODE_ABSY:
                begin
                    if (st.phase == 3'd0)
                    begin
                        st_next.low_byte = word.bus_data;
                        st_next.pointer  = st.pc + 16'd1;
                    end
                    else if (st.phase == 3'd1)
                        st_next.pointer = hi_lo + {ZP_PAGE, abs_idx};
                    else
                    begin
                        res.kind           = KIND_DONE;
                        res.effective_addr = st.pointer;
                        res.operand_value  = {ZP_PAGE, word.bus_data};
                    end
                end
                MODE_INDX, MODE_INDY:
                begin
                    if (st.phase == 3'd0)
                        st_next.pointer = {ZP_PAGE, zp_sum};
                    else if (st.phase == 3'd1)
                    begin
                        st_next.low_byte = word.bus_data;
                        st_next.pointer  = {ZP_PAGE, ptr_inc};
                    end
                    else if (st.phase == 3'd2)
                        st_next.pointer = hi_lo + {ZP_PAGE, abs_idx};
                    else
                    begin
                        res.kind           = KIND_DONE;
                        res.effective_addr = st.pointer;
                        res.operand_value  = {ZP_PAGE, word.bus_data};
                    end
                end
                MODE_IND:
                begin
                    if (st.phase == 3'd0)
                    begin
                        st_next.low_byte = word.bus_data;
                        st_next.pointer  = st.pc + 16'd1;
                    end
                    else if (st.phase == 3'd1)
                        st_next.pointer = hi_lo;
                    else if (st.phase == 3'd2)
                    begin
                        st_next.low_byte = word.bus_data;
                        st_next.pointer  = st.pointer + 16'd1;
                    end
                    else
                    begin
                        res.kind          = KIND_DONE;
                        res.operand_value = hi_lo;
                    end
                end
                default:
                begin
                    res.kind = KIND_DONE;
                end
            endcase
            if (res.kind == KIND_DONE)
            begin
                st_next.busy  = 1'b0;
                st_next.phase = '0;
                res.next_pc   = st.pc + len;
            end
            else
                res.read_addr = st_next.pointer;
        end
    end
endmodule

/* src/coau_out_buf.sv */
// coau_out_buf: result register with a skid stage behind it
// depends on coau_pkg
module coau_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  coau_pkg::out_word_t push_word,
    output logic                can_push,
    output logic                out_valid,
    input  logic                out_ready,
    output coau_pkg::out_word_t out_word
);
    import coau_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t out_word_reg, out_word_next;
    out_word_t skid_word_reg, skid_word_next;
    logic      pop;

    assign pop       = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_word_next  = push_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = push_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end
endmodule

/* src/cpu_operand_address_unit_core.sv */
// cpu_operand_address_unit_core: 6502 operand fetch sequencer, top level
// depends on coau_pkg, coau_in_if, coau_out_if, coau_step, coau_out_buf
//
//   channel | dir | words
//   cmd     | in  | start of a fetch or one bus byte
//   rsp     | out | bus read request or completed operand
//
// one word in, one word out; a word is taken every cycle while the skid
// stage is empty; its result is registered in the output or the skid stage
// the sequencer state lives in one register bank updated on each accepted word
// a stall on rsp fills the skid stage, then holds cmd.ready low
// rst_n clears the sequencer to idle and empties both output stages
module cpu_operand_address_unit_core (
    input  logic       clk,
    input  logic       rst_n,
    coau_in_if.sink    cmd,
    coau_out_if.source rsp
);
    import coau_pkg::*;

    seq_state_t st_reg, st_next;
    in_word_t   word;
    out_word_t  res;
    out_word_t  rsp_word;
    logic       can_push;
    logic       accept;

    assign word = '{func: cmd.func, mode: cmd.mode, start_pc: cmd.start_pc,
                    index_x: cmd.index_x, index_y: cmd.index_y, bus_data: cmd.bus_data};
    assign cmd.ready = can_push;
    assign accept    = cmd.valid && can_push;

    coau_step u_step (
        .st      (st_reg),
        .word    (word),
        .st_next (st_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (accept)
            st_reg <= st_next;
    end

    coau_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (res),
        .can_push  (can_push),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_word  (rsp_word)
    );

    assign rsp.kind           = rsp_word.kind;
    assign rsp.read_addr      = rsp_word.read_addr;
    assign rsp.effective_addr = rsp_word.effective_addr;
    assign rsp.operand_value  = rsp_word.operand_value;
    assign rsp.next_pc        = rsp_word.next_pc;
    assign rsp.protocol_error = rsp_word.protocol_error;
endmodule
